// File: design/skh_pkg.sv
// string key hash package: field widths, hash mode codes and the per-byte
// fold and final mix functions shared by the datapath modules
`default_nettype none

package skh_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned HashW = 32;
  localparam int unsigned ModeW = 2;
  localparam logic [HashW-1:0] MulConst = HashW'(997);
  localparam logic [HashW-1:0] ElfTopMask = 32'hF000_0000;

  typedef enum logic [ModeW-1:0] {
    MODE_MUL997 = 2'd0,
    MODE_ELF    = 2'd1,
    MODE_OAT    = 2'd2
  } hash_mode_e;

  // finished-key beat handed from the fold stage to the final mix stage
  typedef struct packed {
    logic             vld;
    logic [HashW-1:0] val;
  } skh_fin_t;

  function automatic logic [HashW-1:0] asr(input logic [HashW-1:0] v, input int unsigned n);
    asr = HashW'($signed(v) >>> n);
  endfunction

  function automatic logic [HashW-1:0] sext_byte(input logic [ByteW-1:0] b);
    sext_byte = {{(HashW-ByteW){b[ByteW-1]}}, b};
  endfunction

  function automatic logic [HashW-1:0] fold_byte(input logic [HashW-1:0] v,
                                                 input logic [HashW-1:0] c,
                                                 input logic [ModeW-1:0] mode);
    logic [HashW-1:0] t;
    logic [HashW-1:0] g;
    t = '0;
    g = '0;
    unique case (mode)
      MODE_ELF: begin
        t = (v << 4) + c;
        g = t & ElfTopMask;
        t = (t ^ (g >> 24)) & ~g;
      end
      MODE_OAT: begin
        t = v + c;
        t = t + (t << 10);
        t = t ^ asr(t, 6);
      end
      default: begin
        t = v * MulConst + c;
      end
    endcase
    fold_byte = t;
  endfunction

  function automatic logic [HashW-1:0] finish(input logic [HashW-1:0] v,
                                              input logic [ModeW-1:0] mode);
    logic [HashW-1:0] t;
    t = '0;
    unique case (mode)
      MODE_ELF: begin
        t = v;
      end
      MODE_OAT: begin
        t = v + (v << 3);
        t = t ^ asr(t, 11);
        t = t + (t << 15);
      end
      default: begin
        t = v + asr(v, 5);
      end
    endcase
    finish = t;
  endfunction

endpackage

`default_nettype wire

// File: design/skh_in_if.sv
// key byte channel: valid/ready handshake carrying one key byte per beat
// depends on skh_pkg for the field widths
`default_nettype none

interface skh_in_if import skh_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] char_byte;
  logic             end_of_key;

  modport source (output valid, output char_byte, output end_of_key, input ready);
  modport sink   (input valid, input char_byte, input end_of_key, output ready);
endinterface

`default_nettype wire

// File: design/skh_out_if.sv
// hash result channel: valid/ready handshake carrying one 32-bit hash per beat
// depends on skh_pkg for the field width
`default_nettype none

interface skh_out_if import skh_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [HashW-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// File: design/skh_fold.sv
// fold stage: input register, running accumulator and terminator flag,
// hands the folded value of a finished key on; depends on skh_pkg
`default_nettype none

module skh_fold import skh_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] char_byte_i,
  input  wire logic             end_of_key_i,
  output skh_fin_t              fin_o,
  input  wire logic             fin_ready_i
);

  logic             s1_vld_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_eok_q;
  logic [HashW-1:0] acc_q, acc_d;
  logic             term_q, term_d;
  skh_fin_t         fin_q, fin_d;
  logic             fin_free;
  logic             s1_adv;
  logic             s1_load;
  logic [HashW-1:0] folded;

  assign fin_free   = !fin_q.vld || fin_ready_i;
  assign s1_adv     = s1_vld_q && (!s1_eok_q || fin_free);
  assign s1_load    = !s1_vld_q || s1_adv;
  assign in_ready_o = s1_load;
  assign fin_o      = fin_q;

  always_comb begin
    folded = acc_q;
    term_d = term_q;
    if (!term_q) begin
      if (s1_byte_q == '0) begin
        term_d = 1'b1;
      end else begin
        folded = fold_byte(acc_q, sext_byte(s1_byte_q), mode_i);
      end
    end
    acc_d = folded;
    fin_d = fin_q;
    if (fin_ready_i) begin
      fin_d.vld = 1'b0;
    end
    if (s1_adv && s1_eok_q) begin
      fin_d.vld = 1'b1;
      fin_d.val = folded;
      acc_d     = '0;
      term_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      acc_q    <= '0;
      term_q   <= 1'b0;
      fin_q    <= '0;
    end else begin
      if (s1_load) begin
        s1_vld_q <= in_valid_i;
      end
      if (s1_adv) begin
        acc_q  <= acc_d;
        term_q <= term_d;
      end
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_byte_q <= char_byte_i;
      s1_eok_q  <= end_of_key_i;
    end
  end

endmodule

`default_nettype wire

// File: design/skh_final.sv
// final mix stage: applies the per-mode finishing mix and holds the result
// beat until taken; depends on skh_pkg
`default_nettype none

module skh_final import skh_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire skh_fin_t         fin_i,
  output logic                  fin_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [HashW-1:0]      hash_value_o
);

  logic             out_vld_q;
  logic [HashW-1:0] out_val_q;

  assign fin_ready_o  = !out_vld_q || out_ready_i;
  assign out_valid_o  = out_vld_q;
  assign hash_value_o = out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_ready_o) begin
      out_vld_q <= fin_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready_o && fin_i.vld) begin
      out_val_q <= finish(fin_i.val, mode_i);
    end
  end

endmodule

`default_nettype wire

// File: design/string_key_hash_core.sv
// string key hash core: hashes a key fed one byte per beat into 32 bits
// depends on skh_pkg, skh_in_if, skh_out_if, skh_fold and skh_final
//
// in_i carries char_byte and end_of_key; out_o carries hash_value, one beat
// for every key beat with end_of_key set. a zero byte ends the key and the
// bytes after it are ignored until the end beat.
// cfg_we_i/cfg_wdata_i write the hash mode (0 multiply-997, 1 elf,
// 2 one-at-a-time, 3 as 0); write it only while the core is idle.
// throughput: one key byte per cycle while no end beat waits on a full
// hand-off register. a byte is folded into the accumulator from the input
// register; an end beat's hash then goes through the hand-off and output registers.
// the stages are input register, fold stage with a one-entry hand-off
// register, and the output register. bytes that end no key keep flowing while
// a result waits on out_o; a stalled receiver holds in_i back only once an end
// beat and a finished hash are queued behind the waiting result.
// reset clears the accumulator, the terminator flag, all valid bits and sets
// the mode to 0.
`default_nettype none

module string_key_hash_core import skh_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  skh_in_if.sink                in_i,
  skh_out_if.source             out_o,
  input  wire logic             cfg_we_i,
  input  wire logic [ModeW-1:0] cfg_wdata_i
);

  logic [ModeW-1:0] mode_q;
  skh_fin_t         fin;
  logic             fin_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MUL997;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  skh_fold u_fold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .char_byte_i  (in_i.char_byte),
    .end_of_key_i (in_i.end_of_key),
    .fin_o        (fin),
    .fin_ready_i  (fin_ready)
  );

  skh_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .fin_i        (fin),
    .fin_ready_o  (fin_ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .hash_value_o (out_o.hash_value)
  );

  // a finished hash waiting on the final stage keeps its value
  a_fin_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin.vld && !fin_ready) |=> (fin.vld && $stable(fin.val)))
    else $error("finished hash changed while stalled");

  // input is held back only when the hand-off register is full and stalled
  a_in_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (fin.vld && !fin_ready))
    else $error("input stalled without a full hand-off");

  // a new result beat only follows a finished hash in the cycle before
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(fin.vld))
    else $error("result beat without a finished hash");

endmodule

`default_nettype wire
